### src/telnet_line_editor_assert.svh
// Assertion macros for the telnet line editor, used by the tle_ctrl sequencer.
`ifndef TELNET_LINE_EDITOR_ASSERT_SVH
`define TELNET_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tle_pkg.sv
// Types, codes and constants of the telnet line editor.
`default_nettype none
package tle_pkg;

	localparam int LINE_BYTES_DEF = 32;

	localparam logic [7:0] CH_IAC = 8'hFF;
	localparam logic [7:0] CH_SE  = 8'hF0;
	localparam logic [7:0] CH_SB  = 8'hFA;
	localparam logic [7:0] CH_DONT = 8'hFE;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [1:0] BS_STEP_LAST     = 2'd2;
	localparam logic [1:0] PROMPT_STEP_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_BS,
		ST_NL,
		ST_LINE,
		ST_END,
		ST_PROMPT
	} state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ECHO,
		ACT_BS,
		ACT_CR
	} act_t;

	typedef enum logic [2:0] {
		SEL_HOLD,
		SEL_BS,
		SEL_LF,
		SEL_MEM,
		SEL_ZERO,
		SEL_PROMPT
	} sel_t;

	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] kind;
		sel_t       sel;
		logic       last;
		logic       clr_len;
		logic       idx_clr;
		logic       idx_inc;
		logic       step_clr;
		logic       step_inc;
	} tle_cmd_t;

	typedef struct packed {
		act_t       act;
		logic       slot_free;
		logic       len_zero;
		logic       idx_last;
		logic [1:0] step;
	} tle_sts_t;

	function automatic logic [7:0] prompt_byte(input logic [1:0] i);
		logic [7:0] b;
		case (i)
			2'd0:    b = 8'h2D;
			2'd1:    b = 8'h2D;
			2'd2:    b = 8'h3E;
			default: b = 8'h20;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

### src/telnet_line_editor.sv
// Top level of the telnet receive filter with a one-line editor.
// Takes one received byte per item, strips telnet commands (IAC toggling, option bytes after
// FB..FE, subnegotiation up to IAC SE), echoes and stores printable bytes while the line has
// room, handles backspace/DEL, and on CR sends a line feed, the stored line, an end mark and the prompt.
// Each item is worked alone: a new byte is taken only once every result of the last one has
// been issued. While out_ready stays high, the CR readout pace is one stored byte per cycle
// through the single read port of the line memory feeding the one-entry output register.
// The line memory needs no clearing after reset.
`default_nettype none
module telnet_line_editor import tle_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      out_kind,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	tle_cmd_t cmd;
	tle_sts_t sts;

	tle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	tle_datapath #(
		.LINE_BYTES (LINE_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
`default_nettype wire

### src/tle_datapath.sv
// Telnet filter state, line store, readout counters and output register.
`default_nettype none
module tle_datapath import tle_pkg::*; #(
	parameter int LINE_BYTES = LINE_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire logic       out_ready,
	input  wire tle_cmd_t   cmd,
	output tle_sts_t        sts,
	output logic            out_valid,
	output logic [1:0]      out_kind,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	localparam int LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

	logic             in_command_q;
	logic [7:0]       last_command_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [1:0]       step_q, step_d;
	logic [7:0]       hold_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       mem [LINE_BYTES];
	logic             out_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic cmd_path, opt_skip;
	act_t act;
	logic [7:0] sel_byte;

	always_comb begin
		cmd_path = (in_byte == CH_IAC) || in_command_q;
		opt_skip = (last_command_q inside {[CH_SB:CH_DONT]});
		act = ACT_NONE;
		if (cmd_path || opt_skip) begin
			act = ACT_NONE;
		end else if (in_byte == CH_CR) begin
			act = ACT_CR;
		end else if (in_byte == CH_BS || in_byte == CH_DEL) begin
			act = (len_q != '0) ? ACT_BS : ACT_NONE;
		end else if (in_byte inside {[CH_SP:CH_TILDE]}) begin
			act = (len_q < LEN_MAX) ? ACT_ECHO : ACT_NONE;
		end
	end

	always_comb begin
		idx_d = idx_q;
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + LEN_W'(1);
		end
		step_d = step_q;
		if (cmd.step_clr) begin
			step_d = '0;
		end else if (cmd.step_inc) begin
			step_d = step_q + 2'd1;
		end
	end

	always_comb begin
		case (cmd.sel)
			SEL_HOLD:   sel_byte = hold_q;
			SEL_BS:     sel_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
			SEL_LF:     sel_byte = CH_LF;
			SEL_MEM:    sel_byte = rd_data_q;
			SEL_PROMPT: sel_byte = prompt_byte(step_q);
			default:    sel_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_command_q   <= 1'b0;
			last_command_q <= 8'h00;
			len_q          <= '0;
			idx_q          <= '0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			idx_q  <= idx_d;
			step_q <= step_d;
			if (cmd.load) begin
				if (cmd_path) begin
					// inside a subnegotiation only SE ends the pending command
					if (in_byte == CH_SE || last_command_q != CH_SB) begin
						last_command_q <= in_byte;
					end
					in_command_q <= !in_command_q;
				end else if (opt_skip) begin
					if (last_command_q != CH_SB) begin
						last_command_q <= 8'h00;
					end
				end
				case (act)
					ACT_BS:   len_q <= len_q - LEN_W'(1);
					ACT_ECHO: len_q <= len_q + LEN_W'(1);
					default:  len_q <= len_q;
				endcase
			end else if (cmd.clr_len) begin
				len_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hold_q <= in_byte;
		end
		if (cmd.load && act == ACT_ECHO) begin
			mem[len_q] <= in_byte;
		end
		rd_data_q <= mem[idx_d];
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			byte_q <= sel_byte;
			last_q <= cmd.last;
		end
	end

	always_comb begin
		sts.act       = act;
		sts.slot_free = !out_valid_q || out_ready;
		sts.len_zero  = (len_q == '0);
		sts.idx_last  = (idx_q == (len_q - LEN_W'(1)));
		sts.step      = step_q;
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

### src/tle_ctrl.sv
// Sequencer that walks each accepted item through its run of results.
`default_nettype none
`include "telnet_line_editor_assert.svh"
module tle_ctrl import tle_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire tle_sts_t sts,
	output logic          in_ready,
	output tle_cmd_t      cmd
);

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.act)
						ACT_ECHO: state_d = ST_ECHO;
						ACT_BS:   state_d = ST_BS;
						ACT_CR:   state_d = ST_NL;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ECHO: begin
				if (sts.slot_free) state_d = ST_IDLE;
			end
			ST_BS: begin
				if (sts.slot_free && sts.step == BS_STEP_LAST) state_d = ST_IDLE;
			end
			ST_NL: begin
				if (sts.slot_free) state_d = sts.len_zero ? ST_END : ST_LINE;
			end
			ST_LINE: begin
				if (sts.slot_free && sts.idx_last) state_d = ST_END;
			end
			ST_END: begin
				if (sts.slot_free) state_d = ST_PROMPT;
			end
			ST_PROMPT: begin
				if (sts.slot_free && sts.step == PROMPT_STEP_LAST) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.kind     = KIND_ECHO;
		cmd.sel      = SEL_ZERO;
		cmd.last     = 1'b0;
		cmd.clr_len  = 1'b0;
		cmd.idx_clr  = 1'b0;
		cmd.idx_inc  = 1'b0;
		cmd.step_clr = 1'b0;
		cmd.step_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load     = in_valid;
				cmd.idx_clr  = 1'b1;
				cmd.step_clr = 1'b1;
			end
			ST_ECHO: begin
				cmd.emit = sts.slot_free;
				cmd.sel  = SEL_HOLD;
				cmd.last = 1'b1;
			end
			ST_BS: begin
				cmd.emit     = sts.slot_free;
				cmd.sel      = SEL_BS;
				cmd.last     = (sts.step == BS_STEP_LAST);
				cmd.step_inc = sts.slot_free;
			end
			ST_NL: begin
				cmd.emit = sts.slot_free;
				cmd.sel  = SEL_LF;
			end
			ST_LINE: begin
				cmd.emit    = sts.slot_free;
				cmd.kind    = KIND_LINE;
				cmd.sel     = SEL_MEM;
				cmd.idx_inc = sts.slot_free;
			end
			ST_END: begin
				cmd.emit    = sts.slot_free;
				cmd.kind    = KIND_END;
				cmd.sel     = SEL_ZERO;
				cmd.clr_len = sts.slot_free;
			end
			ST_PROMPT: begin
				cmd.emit     = sts.slot_free;
				cmd.sel      = SEL_PROMPT;
				cmd.last     = (sts.step == PROMPT_STEP_LAST);
				cmd.step_inc = sts.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TLE_ASSERT_NOW(a_line_nonempty, state_q == ST_LINE, !sts.len_zero,
		"line readout entered with an empty line")
	`TLE_ASSERT_NEXT(a_bs_start, cmd.load && sts.act == ACT_BS,
		state_q == ST_BS && sts.step == 2'd0, "backspace echo did not start at step zero")
	`TLE_ASSERT_NOW(a_emit_room, cmd.emit, sts.slot_free,
		"result issued while output register is occupied")

endmodule
`default_nettype wire

### tb/telnet_line_editor_tb.sv
// Self-checking testbench for the telnet line editor: directed table, then random sessions.
`default_nettype none
module telnet_line_editor_tb import tle_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_BYTES = LINE_BYTES_DEF;
	localparam int RANDOM_ITEMS = 480;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 2 * LINE_BYTES + 20;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_WILL = 8'hFB;
	localparam logic [7:0] CH_NOP = 8'hF1;
	localparam logic [7:0] CH_GA = 8'hF9;
	localparam logic [7:0] PROMPT [4] = '{8'h2D, 8'h2D, 8'h3E, 8'h20};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	// One stimulus item; typed rows carry their expected single result (or none).
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       has_res;
		logic [1:0] kind;
		logic [7:0] data;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       out_last;

	// Editor state mirrored by the predictor
	logic       ed_in_cmd;
	logic [7:0] ed_last_cmd;
	logic [5:0] ed_len;
	logic [7:0] ed_line [LINE_BYTES];

	res_t pending_out[$];
	row_t sent_rows[$];
	int   errors;
	bit   tx_steady;
	bit   rx_steady;
	bit   hold_go;
	bit   hold_done;

	row_t script [25] = '{
		'{8'h20,    1'b1, 1'b1, KIND_ECHO, 8'h20},
		'{CH_TILDE, 1'b1, 1'b1, KIND_ECHO, CH_TILDE},
		'{CH_NUL,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h80,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_DONT,  1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_BS,    1'b0, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_DEL,   1'b0, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_DEL,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_CR,    1'b0, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_IAC,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_IAC,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h41,    1'b1, 1'b1, KIND_ECHO, 8'h41},
		'{CH_IAC,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_WILL,  1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h01,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_IAC,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_SB,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h18,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h41,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_IAC,   1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{CH_SE,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h7A,    1'b1, 1'b1, KIND_ECHO, 8'h7A},
		'{CH_CR,    1'b0, 1'b0, KIND_ECHO, CH_NUL},
		'{8'h1F,    1'b1, 1'b0, KIND_ECHO, CH_NUL},
		'{8'hFE,    1'b1, 1'b0, KIND_ECHO, CH_NUL}
	};

	telnet_line_editor #(
		.LINE_BYTES(LINE_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Work out the results one received byte causes and append them to q.
	function automatic void edit_byte(input logic [7:0] c, ref res_t q[$]);
		int first;
		int i;
		first = q.size();
		if (c == CH_IAC || ed_in_cmd) begin
			if (c == CH_SE || ed_last_cmd != CH_SB)
				ed_last_cmd = c;
			ed_in_cmd = !ed_in_cmd;
		end else if (ed_last_cmd >= CH_SB && ed_last_cmd <= CH_DONT) begin
			// skip the option byte; inside a subnegotiation keep skipping
			if (ed_last_cmd != CH_SB)
				ed_last_cmd = CH_NUL;
		end else if (c == CH_CR) begin
			q.push_back(res_t'{KIND_ECHO, CH_LF, 1'b0});
			for (i = 0; i < ed_len; i++)
				q.push_back(res_t'{KIND_LINE, ed_line[i], 1'b0});
			q.push_back(res_t'{KIND_END, CH_NUL, 1'b0});
			ed_len = '0;
			for (i = 0; i < 4; i++)
				q.push_back(res_t'{KIND_ECHO, PROMPT[i], 1'b0});
		end else if (c == CH_BS || c == CH_DEL) begin
			if (ed_len != 0) begin
				ed_len = ed_len - 6'd1;
				q.push_back(res_t'{KIND_ECHO, CH_BS, 1'b0});
				q.push_back(res_t'{KIND_ECHO, CH_SP, 1'b0});
				q.push_back(res_t'{KIND_ECHO, CH_BS, 1'b0});
			end
		end else if (c >= CH_SP && c <= CH_TILDE) begin
			if (ed_len < LINE_BYTES - 1) begin
				q.push_back(res_t'{KIND_ECHO, c, 1'b0});
				ed_line[ed_len] = c;
				ed_len = ed_len + 6'd1;
			end
		end
		if (q.size() > first)
			q[q.size() - 1].last = 1'b1;
	endfunction

	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic row_t plain(input logic [7:0] b);
		return row_t'{b, 1'b0, 1'b0, KIND_ECHO, CH_NUL};
	endfunction

	task automatic offer(input row_t row);
		int unsigned gap;
		gap = tx_steady ? 0 : gap_cycles();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sent_rows.push_back(row);
		in_valid <= 1'b1;
		in_byte <= row.b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Predict on every accepted input item, check every accepted result.
	always @(posedge clk) begin
		row_t row;
		res_t got;
		res_t want;
		res_t scratch[$];
		if (arst_n) begin
			if (in_valid && in_ready) begin
				row = sent_rows.pop_front();
				if (row.typed) begin
					scratch.delete();
					edit_byte(row.b, scratch);
					if (row.has_res)
						pending_out.push_back(res_t'{row.kind, row.data, 1'b1});
				end else begin
					edit_byte(row.b, pending_out);
				end
			end
			if (out_valid && out_ready) begin
				got = res_t'{out_kind, out_byte, out_last};
				if (pending_out.size() == 0) begin
					$display("%0t: unexpected result kind %0d byte %02h last %0b", $time,
						got.kind, got.data, got.last);
					errors++;
				end else begin
					want = pending_out.pop_front();
					if (got !== want) begin
						$display("%0t: expected kind %0d byte %02h last %0b, got kind %0d byte %02h last %0b",
							$time, want.kind, want.data, want.last, got.kind, got.data, got.last);
						errors++;
					end
				end
			end
		end
	end

	// Receiver: random stalls, steady stretches, and one long hold-off.
	initial begin
		int unsigned stall;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_go && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 99) < 3)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : gap_cycles();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int count;
		int n;
		int i;
		int unsigned pick;
		logic [7:0] cmd;
		errors = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		ed_in_cmd = 1'b0;
		ed_last_cmd = CH_NUL;
		ed_len = '0;
		for (i = 0; i < LINE_BYTES; i++)
			ed_line[i] = CH_NUL;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= CH_NUL;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k])
			offer(script[k]);

		// Random sessions: mostly well-formed typing and telnet commands, some noise.
		hold_go = 1'b1;
		count = 0;
		while (count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 4)
				tx_steady = !tx_steady;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				// long runs fill the line and hit the silent drop
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10);
				for (i = 0; i < n; i++)
					offer(plain(8'($urandom_range(CH_SP, CH_TILDE))));
				count += n;
			end else if (pick < 42) begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					offer(plain($urandom_range(0, 1) ? CH_BS : CH_DEL));
				count += n;
			end else if (pick < 57) begin
				offer(plain(CH_CR));
				count++;
			end else if (pick < 67) begin
				cmd = $urandom_range(0, 1) ? 8'($urandom_range(CH_WILL, CH_DONT))
					: 8'($urandom_range(CH_NOP, CH_GA));
				offer(plain(CH_IAC));
				offer(plain(cmd));
				count += 2;
				if (cmd >= CH_WILL) begin
					offer(plain(8'($urandom_range(0, 255))));
					count++;
				end
			end else if (pick < 72) begin
				offer(plain(CH_IAC));
				offer(plain(CH_IAC));
				count += 2;
			end else if (pick < 82) begin
				offer(plain(CH_IAC));
				offer(plain(CH_SB));
				n = $urandom_range(0, 6);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0) begin
						// escaped IAC inside the subnegotiation
						offer(plain(CH_IAC));
						offer(plain(CH_IAC));
					end else begin
						offer(plain(8'($urandom_range(0, 254))));
					end
				end
				offer(plain(CH_IAC));
				offer(plain(CH_SE));
				count += n + 4;
			end else begin
				offer(plain(8'($urandom_range(0, 255))));
				count++;
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_out.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_out.size());
			errors++;
		end
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
+incdir+src
src/tle_pkg.sv
src/tle_datapath.sv
src/tle_ctrl.sv
src/telnet_line_editor.sv
tb/telnet_line_editor_tb.sv
